// File: hdl/udpf_pkg.sv
// Shared types and constants for the UDP payload port filter.
// No dependencies; imported by udp_payload_port_filter.
package udpf_pkg;

    localparam int unsigned POS_W = 16;
    localparam int unsigned IHL_W = 6;
    localparam int unsigned HDR_W = 7;

    localparam logic [POS_W-1:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [POS_W-1:0] TOT_LEN_HI_POS = 16'd16;
    localparam logic [POS_W-1:0] TOT_LEN_LO_POS = 16'd17;
    localparam logic [POS_W-1:0] PROTO_POS = 16'd23;
    localparam logic [POS_W-1:0] POS_MAX = 16'hffff;
    localparam logic [HDR_W-1:0] ETH_HDR_SHORT = 7'd14;
    localparam logic [HDR_W-1:0] UDP_PORT_HI_OFS = 7'd2;
    localparam logic [HDR_W-1:0] UDP_PORT_LO_OFS = 7'd3;
    localparam logic [HDR_W-1:0] UDP_LAST_OFS = 7'd7;
    localparam logic [IHL_W-1:0] MIN_IP_HDR = 6'd20;
    localparam logic [16:0] UDP_HDR_BYTES = 17'd8;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] DEST_PORT_RESET = 16'd27500;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_DEST_PORT = 3'd0;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_ETH = 3'd1,
        ST_BAD_IHL   = 3'd2,
        ST_NOT_UDP   = 3'd3,
        ST_SHORT_UDP = 3'd4,
        ST_PORT      = 3'd5,
        ST_EMPTY     = 3'd6,
        ST_TRUNC     = 3'd7
    } t_status;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        frame_done;
        t_status     frame_status;
        logic [15:0] payload_length;
    } t_result;

endpackage

// File: hdl/udp_payload_port_filter.sv
// Top level of the UDP payload port filter: header parser and result queue.
// Depends on udpf_pkg.
//
// Usage:
// Frame bytes enter on the input channel (i_in_valid / o_in_ready), one byte
// per transfer, with i_frame_end set on the last captured byte of a frame.
// Each byte is parsed in the cycle it is accepted, so one byte per cycle is
// sustained while o_in_ready stays high. A byte that is payload of a UDP
// datagram for the configured port, or that ends a frame, yields one result
// transfer on the output channel (o_out_valid / i_out_ready), registered;
// other bytes yield nothing. A frame-end result carries the status and,
// for an accepted or truncated frame, the payload length.
// Results wait in an output register backed by one skid entry, so input is
// still taken while the receiver stalls; o_in_ready drops only when both
// entries are full. The destination port lives at APB address 0; the user
// must write it only while the block is idle; the block does not check this.
// Synchronous reset clears the parser state and both result entries and sets
// the destination port to 27500.
module udp_payload_port_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [udpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_frame_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_payload_valid,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_payload_last,
    output logic                           o_frame_done,
    output logic [2:0]                     o_frame_status,
    output logic [15:0]                    o_payload_length
);
    import udpf_pkg::*;

    logic [15:0]      r_dest_port;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IHL_W-1:0] r_ihl, n_ihl;
    logic [15:0]      r_total, n_total;
    logic [7:0]       r_port_hi, n_port_hi;
    logic [15:0]      r_rem, n_rem;
    t_status          r_pend, n_pend;
    logic             r_rej, n_rej;

    t_result          r_out, r_skid, n_res;
    logic             r_out_v, r_skid_v;

    logic [HDR_W-1:0] hdr_end;
    logic [HDR_W-1:0] pos_port_hi, pos_port_lo, pos_udp_last;
    logic [16:0]      len;
    logic             len_bad;
    logic             accept, pop, push, has_res;
    logic             pv, plast;
    t_status          st;

    assign pready = 1'b1;
    assign prdata = {16'd0, r_dest_port};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_port <= DEST_PORT_RESET;
        end else if (psel && penable && pwrite && paddr == REG_DEST_PORT) begin
            r_dest_port <= pwdata[15:0];
        end
    end

    assign hdr_end      = ETH_HDR_SHORT + {1'b0, r_ihl};
    assign pos_port_hi  = hdr_end + UDP_PORT_HI_OFS;
    assign pos_port_lo  = hdr_end + UDP_PORT_LO_OFS;
    assign pos_udp_last = hdr_end + UDP_LAST_OFS;
    assign len     = {1'b0, r_total} - {11'd0, r_ihl} - UDP_HDR_BYTES;
    assign len_bad = len[16] || (len == 17'd0);

    assign o_in_ready = !r_skid_v;
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = r_out_v && i_out_ready;

    always_comb begin
        n_pos     = r_pos;
        n_ihl     = r_ihl;
        n_total   = r_total;
        n_port_hi = r_port_hi;
        n_rem     = r_rem;
        n_pend    = r_pend;
        n_rej     = r_rej;
        pv        = 1'b0;
        plast     = 1'b0;
        if (!r_rej) begin
            priority if (r_pos == ETH_HDR_BYTES) begin
                n_ihl = {i_frame_byte[3:0], 2'b00};
                if (n_ihl < MIN_IP_HDR) begin
                    n_rej  = 1'b1;
                    n_pend = ST_BAD_IHL;
                end
            end else if (r_pos == TOT_LEN_HI_POS) begin
                n_total[15:8] = i_frame_byte;
            end else if (r_pos == TOT_LEN_LO_POS) begin
                n_total[7:0] = i_frame_byte;
            end else if (r_pos == PROTO_POS) begin
                if (i_frame_byte != PROTO_UDP) begin
                    n_rej  = 1'b1;
                    n_pend = ST_NOT_UDP;
                end
            end else if (r_pos > PROTO_POS) begin
                priority if (r_pos == {9'd0, pos_port_hi}) begin
                    n_port_hi = i_frame_byte;
                end else if (r_pos == {9'd0, pos_port_lo}) begin
                    if ({r_port_hi, i_frame_byte} != r_dest_port) begin
                        n_pend = ST_PORT;
                    end
                end else if (r_pos == {9'd0, pos_udp_last}) begin
                    if (r_pend == ST_PORT) begin
                        n_rej = 1'b1;
                    end else if (len_bad) begin
                        n_rej  = 1'b1;
                        n_pend = ST_EMPTY;
                    end else begin
                        n_rem = len[15:0];
                    end
                end else if (r_pos > {9'd0, pos_udp_last} && r_rem != 16'd0) begin
                    pv    = 1'b1;
                    n_rem = r_rem - 16'd1;
                    plast = (n_rem == 16'd0);
                end else begin
                end
            end else begin
            end
        end
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_comb begin
        priority if (n_rej) begin
            st = n_pend;
        end else if (r_pos < ETH_HDR_BYTES - 16'd1) begin
            st = ST_SHORT_ETH;
        end else if (r_pos <= PROTO_POS || r_pos < {9'd0, pos_udp_last}) begin
            st = ST_SHORT_UDP;
        end else if (n_rem != 16'd0) begin
            st = ST_TRUNC;
        end else begin
            st = ST_OK;
        end
    end

    always_comb begin
        n_res.payload_valid  = pv;
        n_res.payload_byte   = pv ? i_frame_byte : 8'd0;
        n_res.payload_last   = plast;
        n_res.frame_done     = i_frame_end;
        n_res.frame_status   = i_frame_end ? st : ST_OK;
        n_res.payload_length = (i_frame_end && (st == ST_OK || st == ST_TRUNC))
                               ? len[15:0] : 16'd0;
    end

    assign has_res = pv || i_frame_end;
    assign push    = accept && has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ihl     <= '0;
            r_total   <= '0;
            r_port_hi <= '0;
            r_rem     <= '0;
            r_pend    <= ST_OK;
            r_rej     <= 1'b0;
        end else if (accept) begin
            if (i_frame_end) begin
                r_pos     <= '0;
                r_ihl     <= '0;
                r_total   <= '0;
                r_port_hi <= '0;
                r_rem     <= '0;
                r_pend    <= ST_OK;
                r_rej     <= 1'b0;
            end else begin
                r_pos     <= n_pos;
                r_ihl     <= n_ihl;
                r_total   <= n_total;
                r_port_hi <= n_port_hi;
                r_rem     <= n_rem;
                r_pend    <= n_pend;
                r_rej     <= n_rej;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (!r_out_v || pop) begin
                r_out_v <= push;
                r_out   <= n_res;
            end else if (push) begin
                r_skid_v <= 1'b1;
                r_skid   <= n_res;
            end
        end else if (pop) begin
            r_out    <= r_skid;
            r_skid_v <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_last   = r_out.payload_last;
    assign o_frame_done     = r_out.frame_done;
    assign o_frame_status   = r_out.frame_status;
    assign o_payload_length = r_out.payload_length;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("Skid entry holds a result while the output register is empty.");

    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.payload_valid || r_out.frame_done))
        else $error("Result carries neither a payload byte nor a frame end.");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.payload_last) |-> r_out.payload_valid)
        else $error("Last marker set on a result without a payload byte.");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.frame_done) |->
        (r_out.frame_status == ST_OK && r_out.payload_length == 16'd0))
        else $error("Status fields set on a result that does not end a frame.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready) |=> (r_out_v && $stable(r_out)))
        else $error("Stalled result changed before its transfer.");

endmodule

// File: sim/tb_udp_payload_port_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for udp_payload_port_filter: frames go in byte by byte,
// and payload bytes and frame status are compared against a built-in parser model.
// Depends on udpf_pkg and udp_payload_port_filter; needs nothing else.
module tb_udp_payload_port_filter;
    import udpf_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    class udpf_scoreboard;
        logic [15:0] dest_port;
        logic [15:0] byte_pos;
        logic [5:0]  hdr_bytes;
        logic [15:0] total_len;
        logic [7:0]  port_hi;
        logic [15:0] remaining;
        t_status     held_status;
        logic        rejected;
        t_result     awaited_results[$];
        int          mismatches;
        int          bytes_in;
        int          payload_bytes;
        int          status_count[8];

        function new();
            dest_port = DEST_PORT_RESET;
            mismatches = 0;
            bytes_in = 0;
            payload_bytes = 0;
            foreach (status_count[i]) status_count[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos = '0;
            hdr_bytes = '0;
            total_len = '0;
            port_hi = '0;
            remaining = '0;
            held_status = ST_OK;
            rejected = 1'b0;
        endfunction

        function void drop_frame(t_status st);
            rejected = 1'b1;
            held_status = st;
        endfunction

        function int udp_payload_len();
            return int'(total_len) - int'(hdr_bytes) - int'(UDP_HDR_BYTES);
        endfunction

        // Advances the parser by one accepted byte and queues the result it causes.
        function void take_frame_byte(logic [7:0] b, logic last);
            int      cur;
            int      h;
            int      len;
            logic    pv;
            logic    plast;
            t_status st;
            t_result r;
            cur = int'(byte_pos);
            h = int'(ETH_HDR_BYTES) + int'(hdr_bytes);
            pv = 1'b0;
            plast = 1'b0;
            bytes_in++;
            if (!rejected) begin
                if (cur == int'(ETH_HDR_BYTES)) begin
                    hdr_bytes = {b[3:0], 2'b00};
                    if (hdr_bytes < MIN_IP_HDR) drop_frame(ST_BAD_IHL);
                end else if (cur == int'(TOT_LEN_HI_POS)) begin
                    total_len[15:8] = b;
                end else if (cur == int'(TOT_LEN_LO_POS)) begin
                    total_len[7:0] = b;
                end else if (cur == int'(PROTO_POS)) begin
                    if (b != PROTO_UDP) drop_frame(ST_NOT_UDP);
                end else if (cur > int'(PROTO_POS)) begin
                    if (cur == h + int'(UDP_PORT_HI_OFS)) begin
                        port_hi = b;
                    end else if (cur == h + int'(UDP_PORT_LO_OFS)) begin
                        if ({port_hi, b} != dest_port) held_status = ST_PORT;
                    end else if (cur == h + int'(UDP_LAST_OFS)) begin
                        if (held_status == ST_PORT) begin
                            drop_frame(ST_PORT);
                        end else begin
                            len = udp_payload_len();
                            if (len < 1) drop_frame(ST_EMPTY);
                            else remaining = 16'(len);
                        end
                    end else if (cur > h + int'(UDP_LAST_OFS) && remaining > 0) begin
                        pv = 1'b1;
                        remaining = remaining - 16'd1;
                        plast = (remaining == 0);
                    end
                end
            end
            if (byte_pos != POS_MAX) byte_pos = byte_pos + 16'd1;
            if (!pv && !last) return;

            r = '0;
            r.payload_valid = pv;
            r.payload_byte = pv ? b : 8'h00;
            r.payload_last = plast;
            r.frame_done = last;
            r.frame_status = ST_OK;
            if (pv) payload_bytes++;
            if (last) begin
                if (rejected) st = held_status;
                else if (cur < int'(ETH_HDR_BYTES) - 1) st = ST_SHORT_ETH;
                else if (cur <= int'(PROTO_POS) || cur < h + int'(UDP_LAST_OFS))
                    st = ST_SHORT_UDP;
                else if (remaining > 0) st = ST_TRUNC;
                else st = ST_OK;
                r.frame_status = st;
                if (st == ST_OK || st == ST_TRUNC) r.payload_length = 16'(udp_payload_len());
                status_count[st]++;
                clear_frame();
            end
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_result act);
            t_result e;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pv=%0b byte=%02h last=%0b done=%0b st=%0d len=%0d",
                             act.payload_valid, act.payload_byte, act.payload_last,
                             act.frame_done, act.frame_status, act.payload_length);
                return;
            end
            e = awaited_results.pop_front();
            if (act.payload_valid !== e.payload_valid || act.payload_byte !== e.payload_byte ||
                act.payload_last !== e.payload_last || act.frame_done !== e.frame_done ||
                act.frame_status !== e.frame_status ||
                act.payload_length !== e.payload_length) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected pv=%0b byte=%02h last=%0b done=%0b st=%0d len=%0d",
                             e.payload_valid, e.payload_byte, e.payload_last,
                             e.frame_done, e.frame_status, e.payload_length);
                    $display("          actual   pv=%0b byte=%02h last=%0b done=%0b st=%0d len=%0d",
                             act.payload_valid, act.payload_byte, act.payload_last,
                             act.frame_done, act.frame_status, act.payload_length);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_frame_byte = '0;
    logic               i_frame_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_payload_valid;
    logic [7:0]         o_payload_byte;
    logic               o_payload_last;
    logic               o_frame_done;
    logic [2:0]         o_frame_status;
    logic [15:0]        o_payload_length;

    udpf_scoreboard sb;
    logic [7:0]     frame_buf[$];
    int             in_idle_pct = 0;
    int             out_stall_pct = 0;
    int             quiet_cycles = 0;

    udp_payload_port_filter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_frame_byte    (i_frame_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_last  (o_payload_last),
        .o_frame_done    (o_frame_done),
        .o_frame_status  (o_frame_status),
        .o_payload_length(o_payload_length)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.take_frame_byte(i_frame_byte, i_frame_end);
            if (o_out_valid && i_out_ready)
                sb.check_result({o_payload_valid, o_payload_byte, o_payload_last,
                                 o_frame_done, o_frame_status, o_payload_length});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("udp_payload_port_filter regression: fail");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.dest_port = data[15:0];
    endtask

    // Holds the input low until every queued result has come back, plus a margin.
    task automatic wait_drained(input int margin);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_results.size() != 0);
        repeat (margin) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_frame_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // A tot_len of -1 means the length that fits the payload; a cut of 0 keeps the whole
    // frame; a fill of -1 gives random payload and padding bytes.
    task automatic build_frame(input int ihl, input int tot_len, input int proto,
                               input logic [15:0] port, input int plen, input int pad,
                               input int cut, input int fill);
        int hb;
        int n;
        int tot;
        hb = int'(ETH_HDR_BYTES) + 4 * ihl;
        n = hb + 8 + plen + pad;
        tot = (tot_len < 0) ? 4 * ihl + 8 + plen : tot_len;
        frame_buf.delete();
        for (int i = 0; i < n; i++)
            frame_buf.push_back((fill >= 0 && i >= hb + 8) ? 8'(fill) : 8'($urandom));
        frame_buf[hb + 2] = port[15:8];
        frame_buf[hb + 3] = port[7:0];
        frame_buf[ETH_HDR_BYTES] = {4'($urandom), 4'(ihl)};
        frame_buf[TOT_LEN_HI_POS] = 8'(tot >> 8);
        frame_buf[TOT_LEN_LO_POS] = 8'(tot);
        if (n > int'(PROTO_POS)) frame_buf[PROTO_POS] = 8'(proto);
        if (cut > 0) while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    endtask

    task automatic random_frame();
        int          r;
        int          ihl;
        int          plen;
        int          pad;
        int          hb;
        int          proto;
        logic [15:0] port;
        r = $urandom_range(99);
        ihl = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : 5;
        plen = ($urandom_range(9) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
        pad = ($urandom_range(2) == 0) ? $urandom_range(10, 1) : 0;
        hb = int'(ETH_HDR_BYTES) + 4 * ihl;
        port = sb.dest_port;
        proto = $urandom_range(255);
        if (proto == int'(PROTO_UDP)) proto = 0;
        if (r < 46) begin
            build_frame(ihl, -1, PROTO_UDP, port, plen, pad, 0, -1);
        end else if (r < 54) begin
            build_frame(ihl, -1, PROTO_UDP, port, plen + 1, 0,
                        $urandom_range(hb + 8 + plen, hb + 8), -1);
        end else if (r < 60) begin
            build_frame($urandom_range(4), -1, PROTO_UDP, port, plen, pad, 0, -1);
        end else if (r < 66) begin
            build_frame(ihl, -1, proto, port, plen, pad, 0, -1);
        end else if (r < 74) begin
            build_frame(ihl, -1, PROTO_UDP, port ^ (16'd1 << $urandom_range(15)),
                        plen, pad, 0, -1);
        end else if (r < 80) begin
            build_frame(ihl, $urandom_range(4 * ihl + 8), PROTO_UDP, port, plen, pad, 0, -1);
        end else if (r < 87) begin
            build_frame(ihl, -1, PROTO_UDP, port, plen, pad, $urandom_range(hb + 7, 14), -1);
        end else if (r < 91) begin
            build_frame(ihl, -1, PROTO_UDP, port, plen, pad, $urandom_range(13, 1), -1);
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(80, 1)) frame_buf.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial begin
        logic [15:0] port;
        int          phase_bytes;
        int          frames;
        sb = new();
        frames = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames against the reset port value.
        port = DEST_PORT_RESET;
        build_frame(5, -1, PROTO_UDP, port, 1, 0, 0, 8'hff);   send_frame();
        build_frame(5, -1, PROTO_UDP, port, 3, 6, 0, 8'h00);   send_frame();
        build_frame(15, -1, PROTO_UDP, port, 4, 0, 0, -1);     send_frame();
        build_frame(5, -1, PROTO_UDP, port, 4, 0, 1, -1);      send_frame();
        build_frame(5, -1, PROTO_UDP, port, 4, 0, 13, -1);     send_frame();
        build_frame(5, -1, PROTO_UDP, port, 4, 0, 14, -1);     send_frame();
        build_frame(5, -1, PROTO_UDP, port, 4, 0, 15, -1);     send_frame();
        build_frame(5, -1, PROTO_UDP, port, 4, 0, 41, -1);     send_frame();
        build_frame(0, -1, PROTO_UDP, port, 4, 0, 0, -1);      send_frame();
        build_frame(4, -1, PROTO_UDP, port, 4, 0, 0, -1);      send_frame();
        build_frame(3, -1, PROTO_UDP, port, 4, 0, 16, -1);     send_frame();
        build_frame(5, -1, 6, port, 4, 0, 0, -1);              send_frame();
        build_frame(5, -1, PROTO_UDP, port ^ 16'd1, 4, 0, 0, -1); send_frame();
        build_frame(5, 28, PROTO_UDP, port, 4, 0, 0, -1);      send_frame();
        build_frame(5, 0, PROTO_UDP, port, 4, 0, 0, -1);       send_frame();
        build_frame(5, 16'hffff, PROTO_UDP, port, 6, 0, 0, -1); send_frame();
        build_frame(5, -1, PROTO_UDP, port, 5, 0, 42, -1);     send_frame();
        frames = 17;

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained(8);
            case (ph)
                0: port = 16'hffff;
                1: port = 16'h0000;
                2: port = DEST_PORT_RESET;
                default: port = 16'($urandom);
            endcase
            apb_write(REG_DEST_PORT, {16'($urandom), port});
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 76; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 76; end
                default: begin in_idle_pct = 18; out_stall_pct = 18; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < 24) begin
                if ($urandom_range(11) == 0) wait_drained(0);
                random_frame();
                phase_bytes += frame_buf.size();
                frames++;
            end
        end

        wait_drained(10);
        $display("Run covered %0d frames (%0d bytes, %0d payload bytes) over 8 port settings.",
                 frames, sb.bytes_in, sb.payload_bytes);
        $display("Outcomes ok/short eth/ihl/proto/short udp/port/empty/trunc: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2], sb.status_count[3],
                 sb.status_count[4], sb.status_count[5], sb.status_count[6], sb.status_count[7]);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("udp_payload_port_filter regression: pass");
        end else begin
            $display("udp_payload_port_filter regression: fail");
        end
        $finish;
    end
endmodule

// File: udp_payload_port_filter.f
hdl/udpf_pkg.sv
hdl/udp_payload_port_filter.sv
sim/tb_udp_payload_port_filter.sv
